// ===== rtl/bma_pkg.sv =====
// ----------------------------------------------------------------------------
// bma_pkg
// Shared types, codes and defaults of the buddy memory allocator.
// ----------------------------------------------------------------------------
package bma_pkg;

  localparam int MAX_LEVELS_DEF = 10;
  localparam int NAME_COUNT_DEF = 256;

  localparam int OWNER_W  = 8;
  localparam int COUNT_W  = 31;
  localparam int OFFSET_W = 30;
  localparam int SIZE_W   = 31;
  localparam int STATUS_W = 3;
  localparam int ORDER_W  = 5;
  localparam int STAMP_W  = 32;
  localparam int REG_IDX_W = 1;

  localparam logic [ORDER_W-1:0] TOTAL_ORDER_RST = 5'd8;
  localparam logic [ORDER_W-1:0] MIN_ORDER_RST   = 5'd4;
  localparam logic [ORDER_W-1:0] ORDER_MAX       = 5'd30;

  localparam logic [REG_IDX_W-1:0] REG_TOTAL_ORDER = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_MIN_ORDER   = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NO_FREE   = 3'd1,
    ST_TOO_LARGE = 3'd2,
    ST_UNKNOWN   = 3'd3,
    ST_HELD      = 3'd4,
    ST_BAD_CFG   = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    K_ABSENT = 2'd0,
    K_FREE   = 2'd1,
    K_USED   = 2'd2,
    K_SPLIT  = 2'd3
  } kind_t;

  // node memory write selection
  typedef enum logic [2:0] {
    W_CLR,
    W_ROOT,
    W_N_ABSENT,
    W_SIB_ABSENT,
    W_N_FREE,
    W_N_SPLIT,
    W_RCHILD_FREE,
    W_N_USED
  } wsel_t;

  typedef enum logic {
    R_SIB,
    R_SCAN
  } rsel_t;

  typedef struct packed {
    logic    req_take;
    logic    clr_start;
    logic    clr_step;
    logic    cnt_rst;
    logic    cnt_inc;
    logic    own_vld_clr;
    logic    own_set;
    logic    own_clr;
    logic    chk_n;
    logic    n_up;
    logic    n_down;
    logic    k_init;
    logic    k_inc;
    logic    scan_init;
    logic    scan_eval;
    logic    scan_next_lvl;
    logic    split_init;
    logic    res_err;
    status_t err_code;
    logic    res_place;
    logic    out_load;
    logic    we;
    wsel_t   wsel;
    rsel_t   rsel;
  } cmd_t;

  typedef struct packed {
    logic cfg_wr;
    logic req_valid;
    logic out_free;
    logic clr_last;
    logic cfg_ok;
    logic owner_bad;
    logic is_release;
    logic own_valid;
    logic too_large;
    logic size_more;
    logic n_is_root;
    logic sib_free;
    logic level_end;
    logic best_valid;
    logic lvl_zero;
    logic at_lt_want;
  } stat_t;

endpackage

// ===== rtl/bma_req_if.sv =====
// ----------------------------------------------------------------------------
// bma_req_if
// Request channel: owner name and byte count.
// ----------------------------------------------------------------------------
interface bma_req_if;
  logic                         valid;
  logic                         ready;
  logic [bma_pkg::OWNER_W-1:0]  owner;
  logic [bma_pkg::COUNT_W-1:0]  byte_count;

  modport source (output valid, owner, byte_count, input ready);
  modport sink   (input valid, owner, byte_count, output ready);
endinterface

// ===== rtl/bma_rsp_if.sv =====
// ----------------------------------------------------------------------------
// bma_rsp_if
// Response channel: status, block offset and block size.
// ----------------------------------------------------------------------------
interface bma_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [bma_pkg::STATUS_W-1:0]  status;
  logic [bma_pkg::OFFSET_W-1:0]  block_offset;
  logic [bma_pkg::SIZE_W-1:0]    block_size;

  modport source (output valid, status, block_offset, block_size, input ready);
  modport sink   (input valid, status, block_offset, block_size, output ready);
endinterface

// ===== rtl/bma_cfg_if.sv =====
// ----------------------------------------------------------------------------
// bma_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface bma_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bma_pkg::REG_IDX_W-1:0]  index;
  logic [bma_pkg::ORDER_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/bma_ctrl.sv =====
// ----------------------------------------------------------------------------
// bma_ctrl
// Request sequencer: clearing pass, checks, release merge, size search,
// free-list scan and split, result hand-off.
// ----------------------------------------------------------------------------
module bma_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  bma_pkg::stat_t  st,
  output bma_pkg::cmd_t   cmd
);
  import bma_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR, S_ROOT, S_IDLE, S_CHECK,
    S_REL0, S_REL_CHK, S_REL_EV, S_REL_W2, S_REL_FREE,
    S_SIZE, S_SCAN_INIT, S_SCAN_RD, S_SCAN_EV, S_SCAN_LVL,
    S_SPLIT, S_SPLIT_R, S_DONE
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.wsel   = W_CLR;
    cmd.rsel   = R_SCAN;
    cmd.err_code = ST_OK;
    state_next = state;
    case (state)
      S_CLEAR: begin
        cmd.we = 1'b1;
        cmd.wsel = W_CLR;
        cmd.clr_step = 1'b1;
        if (st.clr_last) state_next = S_ROOT;
      end
      S_ROOT: begin
        cmd.we = 1'b1;
        cmd.wsel = W_ROOT;
        cmd.cnt_rst = 1'b1;
        cmd.own_vld_clr = 1'b1;
        state_next = S_IDLE;
      end
      S_IDLE: begin
        cmd.req_take = 1'b1;
        if (st.req_valid) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (!st.cfg_ok) begin
          cmd.res_err = 1'b1;
          cmd.err_code = ST_BAD_CFG;
          state_next = S_DONE;
        end else if (st.owner_bad) begin
          cmd.res_err = 1'b1;
          cmd.err_code = ST_UNKNOWN;
          state_next = S_DONE;
        end else if (st.is_release) begin
          if (!st.own_valid) begin
            cmd.res_err = 1'b1;
            cmd.err_code = ST_UNKNOWN;
            state_next = S_DONE;
          end else begin
            cmd.chk_n = 1'b1;
            state_next = S_REL0;
          end
        end else if (st.own_valid) begin
          cmd.res_err = 1'b1;
          cmd.err_code = ST_HELD;
          state_next = S_DONE;
        end else if (st.too_large) begin
          cmd.res_err = 1'b1;
          cmd.err_code = ST_TOO_LARGE;
          state_next = S_DONE;
        end else begin
          cmd.k_init = 1'b1;
          state_next = S_SIZE;
        end
      end
      S_REL0: begin
        cmd.res_place = 1'b1;
        cmd.own_clr = 1'b1;
        state_next = S_REL_CHK;
      end
      S_REL_CHK: begin
        cmd.rsel = R_SIB;
        state_next = st.n_is_root ? S_REL_FREE : S_REL_EV;
      end
      S_REL_EV: begin
        if (st.sib_free) begin
          cmd.we = 1'b1;
          cmd.wsel = W_N_ABSENT;
          state_next = S_REL_W2;
        end else begin
          state_next = S_REL_FREE;
        end
      end
      S_REL_W2: begin
        cmd.we = 1'b1;
        cmd.wsel = W_SIB_ABSENT;
        cmd.n_up = 1'b1;
        state_next = S_REL_CHK;
      end
      S_REL_FREE: begin
        cmd.we = 1'b1;
        cmd.wsel = W_N_FREE;
        cmd.cnt_inc = 1'b1;
        state_next = S_DONE;
      end
      S_SIZE: begin
        if (st.size_more) cmd.k_inc = 1'b1;
        else state_next = S_SCAN_INIT;
      end
      S_SCAN_INIT: begin
        cmd.scan_init = 1'b1;
        state_next = S_SCAN_RD;
      end
      S_SCAN_RD: begin
        cmd.rsel = R_SCAN;
        state_next = S_SCAN_EV;
      end
      S_SCAN_EV: begin
        cmd.scan_eval = 1'b1;
        state_next = st.level_end ? S_SCAN_LVL : S_SCAN_RD;
      end
      S_SCAN_LVL: begin
        if (st.best_valid) begin
          cmd.split_init = 1'b1;
          state_next = S_SPLIT;
        end else if (st.lvl_zero) begin
          cmd.res_err = 1'b1;
          cmd.err_code = ST_NO_FREE;
          state_next = S_DONE;
        end else begin
          cmd.scan_next_lvl = 1'b1;
          state_next = S_SCAN_RD;
        end
      end
      S_SPLIT: begin
        cmd.we = 1'b1;
        if (st.at_lt_want) begin
          cmd.wsel = W_N_SPLIT;
          state_next = S_SPLIT_R;
        end else begin
          cmd.wsel = W_N_USED;
          cmd.own_set = 1'b1;
          cmd.res_place = 1'b1;
          state_next = S_DONE;
        end
      end
      S_SPLIT_R: begin
        cmd.we = 1'b1;
        cmd.wsel = W_RCHILD_FREE;
        cmd.cnt_inc = 1'b1;
        cmd.n_down = 1'b1;
        state_next = S_SPLIT;
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
    // any configuration write restarts the heap
    if (st.cfg_wr) begin
      cmd = '0;
      cmd.wsel = W_CLR;
      cmd.rsel = R_SCAN;
      cmd.err_code = ST_OK;
      cmd.clr_start = 1'b1;
      state_next = S_CLEAR;
    end
  end

endmodule

// ===== rtl/bma_dp.sv =====
// ----------------------------------------------------------------------------
// bma_dp
// Datapath: config registers, node memory (kind and free stamp), owner table,
// walk registers, scan comparator and result/output registers.
// ----------------------------------------------------------------------------
module bma_dp #(
  parameter int MAX_LEVELS = bma_pkg::MAX_LEVELS_DEF,
  parameter int NAME_COUNT = bma_pkg::NAME_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  bma_pkg::cmd_t                   cmd,
  output bma_pkg::stat_t                  st,
  input  logic                            cfg_valid,
  input  logic [bma_pkg::REG_IDX_W-1:0]   cfg_index,
  input  logic [bma_pkg::ORDER_W-1:0]     cfg_data,
  input  logic                            req_valid,
  input  logic [bma_pkg::OWNER_W-1:0]     req_owner,
  input  logic [bma_pkg::COUNT_W-1:0]     req_byte_count,
  input  logic                            rsp_ready,
  output logic                            rsp_valid,
  output logic [bma_pkg::STATUS_W-1:0]    rsp_status,
  output logic [bma_pkg::OFFSET_W-1:0]    rsp_block_offset,
  output logic [bma_pkg::SIZE_W-1:0]      rsp_block_size
);
  import bma_pkg::*;

  localparam int NB    = MAX_LEVELS + 1;
  localparam int NODES = 1 << NB;
  localparam int LW    = $clog2(MAX_LEVELS + 1);
  localparam int OW    = $clog2(NAME_COUNT);
  localparam int WORD_W = 2 + STAMP_W;

  // configuration
  logic [ORDER_W-1:0] tot_ord, min_ord;

  always_ff @(posedge clk) begin
    if (rst) begin
      tot_ord <= TOTAL_ORDER_RST;
      min_ord <= MIN_ORDER_RST;
    end else if (cfg_valid) begin
      if (cfg_index == REG_TOTAL_ORDER) tot_ord <= cfg_data;
      else min_ord <= cfg_data;
    end
  end

  logic [ORDER_W-1:0] ord_gap;
  assign ord_gap = tot_ord - min_ord;
  assign st.cfg_ok = (tot_ord != '0) && (tot_ord <= ORDER_MAX) && (min_ord != '0) &&
                     (min_ord < tot_ord) && (ord_gap <= ORDER_W'(MAX_LEVELS));

  // request
  logic [OWNER_W-1:0] owner_q;
  logic [COUNT_W-1:0] bc_q;

  always_ff @(posedge clk) begin
    if (cmd.req_take) begin
      owner_q <= req_owner;
      bc_q    <= req_byte_count;
    end
  end

  assign st.req_valid  = req_valid;
  assign st.cfg_wr     = cfg_valid;
  assign st.owner_bad  = ({1'b0, owner_q} >= (OWNER_W+1)'(NAME_COUNT));
  assign st.is_release = (bc_q == '0);
  assign st.too_large  = ({1'b0, bc_q} > (32'(1) << tot_ord));

  // owner table: node index memory plus valid flops
  logic [NB-1:0]         otab [NAME_COUNT];
  logic [NB-1:0]         otab_rd;
  logic [NAME_COUNT-1:0] own_vld;
  logic [OW-1:0]         own_idx;

  assign own_idx = owner_q[OW-1:0];
  assign st.own_valid = own_vld[own_idx];

  logic [NB-1:0] n;

  always_ff @(posedge clk) begin
    otab_rd <= otab[req_owner[OW-1:0]];
    if (cmd.own_set) otab[own_idx] <= n;
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.own_vld_clr) begin
      own_vld <= '0;
    end else if (cmd.own_set) begin
      own_vld[own_idx] <= 1'b1;
    end else if (cmd.own_clr) begin
      own_vld[own_idx] <= 1'b0;
    end
  end

  // stamp counter
  logic [STAMP_W-1:0] stamp_cnt;

  always_ff @(posedge clk) begin
    if (rst || cmd.cnt_rst) begin
      stamp_cnt <= STAMP_W'(1);
    end else if (cmd.cnt_inc) begin
      stamp_cnt <= stamp_cnt + STAMP_W'(1);
    end
  end

  // clearing pass address
  logic [NB-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst || cmd.clr_start) begin
      clr_addr <= '0;
    end else if (cmd.clr_step) begin
      clr_addr <= clr_addr + NB'(1);
    end
  end

  assign st.clr_last = &clr_addr;

  // walk and scan registers
  logic [NB-1:0]      i_scan, best;
  logic [LW-1:0]      lvl, at, want;
  logic [ORDER_W-1:0] k;
  logic [STAMP_W-1:0] best_age;
  logic               best_vld;

  // node memory
  logic [WORD_W-1:0] node_mem [NODES];
  logic [WORD_W-1:0] node_rd;
  logic [NB-1:0]     rd_addr, wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic [NB-1:0]     sib, rchild;

  assign sib    = n ^ NB'(1);
  assign rchild = {n[NB-2:0], 1'b1};
  assign rd_addr = (cmd.rsel == R_SIB) ? sib : i_scan;

  always_comb begin
    wr_addr = n;
    wr_data = {K_ABSENT, stamp_cnt};
    case (cmd.wsel)
      W_CLR: begin
        wr_addr = clr_addr;
        wr_data = {K_ABSENT, stamp_cnt};
      end
      W_ROOT: begin
        wr_addr = NB'(1);
        wr_data = {K_FREE, STAMP_W'(0)};
      end
      W_N_ABSENT:    wr_data = {K_ABSENT, stamp_cnt};
      W_SIB_ABSENT: begin
        wr_addr = sib;
        wr_data = {K_ABSENT, stamp_cnt};
      end
      W_N_FREE:      wr_data = {K_FREE, stamp_cnt};
      W_N_SPLIT:     wr_data = {K_SPLIT, stamp_cnt};
      W_RCHILD_FREE: begin
        wr_addr = rchild;
        wr_data = {K_FREE, stamp_cnt};
      end
      W_N_USED:      wr_data = {K_USED, stamp_cnt};
      default:       wr_data = {K_ABSENT, stamp_cnt};
    endcase
  end

  always_ff @(posedge clk) begin
    node_rd <= node_mem[rd_addr];
    if (cmd.we) node_mem[wr_addr] <= wr_data;
  end

  logic [1:0]         rd_kind;
  logic [STAMP_W-1:0] rd_stamp, age;
  logic               hit;

  assign rd_kind  = node_rd[WORD_W-1 -: 2];
  assign rd_stamp = node_rd[STAMP_W-1:0];
  assign age      = stamp_cnt - rd_stamp;
  assign hit      = (rd_kind == K_FREE) && (!best_vld || (age < best_age));
  assign st.sib_free = (rd_kind == K_FREE);

  logic [ORDER_W-1:0] want_c;
  logic [NB:0]        lvl_top;
  assign want_c  = tot_ord - k;
  assign lvl_top = (NB+1)'(1) << (lvl + LW'(1));

  assign st.size_more  = ((32'(1) << k) < {1'b0, bc_q});
  assign st.level_end  = (i_scan == NB'(lvl_top - (NB+1)'(1)));
  assign st.best_valid = best_vld;
  assign st.lvl_zero   = (lvl == '0);
  assign st.at_lt_want = (at < want);
  assign st.n_is_root  = (n == NB'(1));

  always_ff @(posedge clk) begin
    if (cmd.k_init) k <= min_ord;
    else if (cmd.k_inc) k <= k + ORDER_W'(1);

    if (cmd.scan_init) begin
      want     <= LW'(want_c);
      lvl      <= LW'(want_c);
      i_scan   <= NB'(1) << want_c;
      best_vld <= 1'b0;
    end else if (cmd.scan_next_lvl) begin
      lvl    <= lvl - LW'(1);
      i_scan <= NB'(1) << (lvl - LW'(1));
    end else if (cmd.scan_eval) begin
      i_scan <= i_scan + NB'(1);
      if (hit) begin
        best     <= i_scan;
        best_age <= age;
        best_vld <= 1'b1;
      end
    end

    if (cmd.chk_n) n <= otab_rd;
    else if (cmd.split_init) n <= best;
    else if (cmd.n_up) n <= n >> 1;
    else if (cmd.n_down) n <= {n[NB-2:0], 1'b0};

    if (cmd.split_init) at <= lvl;
    else if (cmd.n_down) at <= at + LW'(1);
  end

  // block placement of node n
  logic [LW-1:0]       n_lvl;
  logic [ORDER_W-1:0]  n_ord;
  logic [NB-1:0]       n_low;

  always_comb begin
    n_lvl = '0;
    for (int b = 0; b < NB; b++) begin
      if (n[b]) n_lvl = LW'(b);
    end
  end

  assign n_ord = tot_ord - ORDER_W'(n_lvl);
  assign n_low = n & ~(NB'(1) << n_lvl);

  // result and output registers
  logic [STATUS_W-1:0] res_status;
  logic [OFFSET_W-1:0] res_off;
  logic [SIZE_W-1:0]   res_size;

  always_ff @(posedge clk) begin
    if (cmd.res_err) begin
      res_status <= cmd.err_code;
      res_off    <= '0;
      res_size   <= '0;
    end else if (cmd.res_place) begin
      res_status <= ST_OK;
      res_off    <= OFFSET_W'(n_low) << n_ord;
      res_size   <= SIZE_W'(1) << n_ord;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp_status       <= res_status;
      rsp_block_offset <= res_off;
      rsp_block_size   <= res_size;
    end
  end

  assign st.out_free = !rsp_valid || rsp_ready;

endmodule

// ===== rtl/buddy_memory_allocator.sv =====
// ----------------------------------------------------------------------------
// buddy_memory_allocator
// Binary buddy allocator over a heap of 2^total_order bytes.
// ----------------------------------------------------------------------------
// Channels: req carries owner and byte_count (zero releases the owner's
// block), rsp returns status, block_offset and block_size, cfg writes
// total_order (index 0) or min_order (index 1) and always has ready high.
// One request at a time; each gives exactly one response unless a cfg write
// restarts the heap before it is answered. A release merges the freed block
// with free buddies level by level toward the root. An allocation rounds the
// byte count up to a power of two no smaller than 2^min_order, then scans the
// free list one size class at a time from that size upward, reading the node
// memory once per node scanned (at most 2^(MAX_LEVELS+1) - 1 nodes), and
// splits the chosen block down to the wanted size. Reset and every cfg write
// start a clearing pass over all 2^(MAX_LEVELS+1) node memory entries (2048
// by default) with req ready low; the heap is then one free block.
// The response sits in an output register; when rsp stalls, the next request
// is still accepted and worked on, and it waits only to hand over its result.
// ----------------------------------------------------------------------------
module buddy_memory_allocator #(
  parameter int MAX_LEVELS = bma_pkg::MAX_LEVELS_DEF,
  parameter int NAME_COUNT = bma_pkg::NAME_COUNT_DEF
) (
  input logic       clk,
  input logic       rst,
  bma_cfg_if.sink   cfg,
  bma_req_if.sink   req,
  bma_rsp_if.source rsp
);
  import bma_pkg::*;

  cmd_t  cmd;
  stat_t st;

  assign cfg.ready = 1'b1;
  assign req.ready = cmd.req_take;

  bma_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .st  (st),
    .cmd (cmd)
  );

  bma_dp #(
    .MAX_LEVELS (MAX_LEVELS),
    .NAME_COUNT (NAME_COUNT)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .st               (st),
    .cfg_valid        (cfg.valid),
    .cfg_index        (cfg.index),
    .cfg_data         (cfg.data),
    .req_valid        (req.valid),
    .req_owner        (req.owner),
    .req_byte_count   (req.byte_count),
    .rsp_ready        (rsp.ready),
    .rsp_valid        (rsp.valid),
    .rsp_status       (rsp.status),
    .rsp_block_offset (rsp.block_offset),
    .rsp_block_size   (rsp.block_size)
  );

`ifndef SYNTHESIS
  a_clear_after_reset: assert property (@(posedge clk) rst |=> !req.ready)
    else $error("request accepted during clearing pass");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.status != ST_OK) |-> (rsp.block_offset == '0) && (rsp.block_size == '0))
    else $error("error response with nonzero block");

  a_ok_pow2: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.status == ST_OK) |-> $onehot(rsp.block_size))
    else $error("ok response with bad block size");
`endif

endmodule

// ===== dv/buddy_memory_allocator_tb.sv =====
// ----------------------------------------------------------------------------
// buddy_memory_allocator_tb
// Self-checking bench for the buddy allocator. A local model of the block
// tree, free stamps and owner table predicts every response. Requests run
// through directed corner cases, bad and extreme heap settings, and random
// alloc/release traffic under several idle and stall mixes.
// ----------------------------------------------------------------------------
module buddy_memory_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bma_pkg::*;

  localparam int LEVELS    = MAX_LEVELS_DEF;
  localparam int SLOTS     = 1 << (LEVELS + 1);
  localparam int OWN_VLD_B = LEVELS + 1;

  typedef struct packed {
    status_t             st;
    logic [OFFSET_W-1:0] off;
    logic [SIZE_W-1:0]   sz;
  } alloc_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bma_cfg_if cfg_ch ();
  bma_req_if req_ch ();
  bma_rsp_if rsp_ch ();

  buddy_memory_allocator u_top (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // local copy of the allocator state
  kind_t                  tree_kind [SLOTS];
  logic [STAMP_W-1:0]     free_stamp [SLOTS];
  logic [OWN_VLD_B:0]     owner_node [256];
  logic [STAMP_W-1:0]     stamp_now;
  logic [ORDER_W-1:0]     heap_order = TOTAL_ORDER_RST;
  logic [ORDER_W-1:0]     leaf_order = MIN_ORDER_RST;

  alloc_rsp_t pending_rsp[$];
  int         err_cnt  = 0;
  int         send_pct = 0;
  int         stall_pct = 0;

  function automatic void heap_clear();
    foreach (tree_kind[i]) tree_kind[i] = K_ABSENT;
    foreach (owner_node[i]) owner_node[i] = '0;
    tree_kind[1]  = K_FREE;
    free_stamp[1] = '0;
    stamp_now     = 32'd1;
  endfunction

  function automatic bit heap_cfg_ok();
    return heap_order >= 1 && heap_order <= 30 && leaf_order >= 1 &&
           leaf_order < heap_order && (heap_order - leaf_order) <= LEVELS;
  endfunction

  function automatic void mark_free(int unsigned n);
    tree_kind[n]  = K_FREE;
    free_stamp[n] = stamp_now;
    stamp_now     = stamp_now + 32'd1;
  endfunction

  function automatic int unsigned depth_of(int unsigned n);
    int unsigned lvl;
    lvl = 0;
    while (n > 1) begin
      n >>= 1;
      lvl++;
    end
    return lvl;
  endfunction

  function automatic void place_node(int unsigned n, ref alloc_rsp_t r);
    int unsigned      lvl;
    longint unsigned  order;
    lvl   = depth_of(n);
    order = heap_order - lvl;
    r.off = OFFSET_W'(longint'(n - (1 << lvl)) << order);
    r.sz  = SIZE_W'(64'd1 << order);
  endfunction

  function automatic alloc_rsp_t predict_block(logic [7:0] owner, logic [30:0] cnt);
    alloc_rsp_t       r;
    int unsigned      n, at, want, k, age, best_age, best;
    int               l, i;
    r = '{ST_OK, '0, '0};
    if (!heap_cfg_ok()) begin
      r.st = ST_BAD_CFG;
    end else if (cnt == 0) begin
      if (!owner_node[owner][OWN_VLD_B]) begin
        r.st = ST_UNKNOWN;
      end else begin
        n = owner_node[owner][OWN_VLD_B-1:0];
        place_node(n, r);
        owner_node[owner] = '0;
        tree_kind[n] = K_FREE;
        // merge free buddies upward
        while (n > 1 && tree_kind[n ^ 1] == K_FREE) begin
          tree_kind[n]     = K_ABSENT;
          tree_kind[n ^ 1] = K_ABSENT;
          n >>= 1;
        end
        mark_free(n);
      end
    end else if (owner_node[owner][OWN_VLD_B]) begin
      r.st = ST_HELD;
    end else if (64'(cnt) > (64'd1 << heap_order)) begin
      r.st = ST_TOO_LARGE;
    end else begin
      k = leaf_order;
      while ((64'd1 << k) < 64'(cnt)) k++;
      want = heap_order - k;
      best = 0;
      for (l = want; l >= 0 && best == 0; l--) begin
        best_age = 0;
        for (i = 1 << l; i < (2 << l); i++) begin
          if (tree_kind[i] == K_FREE) begin
            age = stamp_now - free_stamp[i];
            if (best == 0 || age < best_age) begin
              best     = i;
              best_age = age;
            end
          end
        end
      end
      if (best == 0) begin
        r.st = ST_NO_FREE;
      end else begin
        n  = best;
        at = depth_of(n);
        // keep the left half, free the right half
        while (at < want) begin
          tree_kind[n] = K_SPLIT;
          mark_free(2 * n + 1);
          tree_kind[2 * n] = K_FREE;
          n  = 2 * n;
          at++;
        end
        tree_kind[n] = K_USED;
        owner_node[owner] = {1'b1, OWN_VLD_B'(n)};
        place_node(n, r);
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    err_cnt++;
  endtask

  // response side: random stall and in-order compare
  always @(posedge clk) begin
    alloc_rsp_t e;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (pending_rsp.size() == 0) begin
          report_mismatch("unexpected response", rsp_ch.status, -1);
        end else begin
          e = pending_rsp.pop_front();
          if (rsp_ch.status !== e.st) report_mismatch("status", rsp_ch.status, e.st);
          if (rsp_ch.block_offset !== e.off)
            report_mismatch("block_offset", rsp_ch.block_offset, e.off);
          if (rsp_ch.block_size !== e.sz)
            report_mismatch("block_size", rsp_ch.block_size, e.sz);
        end
      end
      rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic send_req(logic [7:0] owner, logic [30:0] cnt);
    req_ch.valid      <= 1'b1;
    req_ch.owner      <= owner;
    req_ch.byte_count <= cnt;
    do @(posedge clk); while (!req_ch.ready);
    pending_rsp.push_back(predict_block(owner, cnt));
    if ($urandom_range(0, 99) < send_pct) begin
      req_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_pct);
    end
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  // leaves cfg valid high; the caller drops it after the last write
  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [ORDER_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == REG_TOTAL_ORDER) heap_order = val;
    else leaf_order = val;
    heap_clear();
  endtask

  task automatic set_heap(int tot, int mn);
    drain();
    write_reg(REG_TOTAL_ORDER, ORDER_W'(tot));
    write_reg(REG_MIN_ORDER, ORDER_W'(mn));
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic test_directed();
    // default heap: 256 bytes, 16-byte leaves
    send_req(8'd0, 31'd1);
    send_req(8'd0, 31'd5);
    send_req(8'd1, 31'd0);
    send_req(8'd1, 31'd257);
    send_req(8'd1, 31'd256);
    send_req(8'd1, 31'd17);
    send_req(8'd2, 31'd16);
    send_req(8'd3, 31'd100);
    send_req(8'd0, 31'd0);
    send_req(8'd2, 31'd0);
    send_req(8'd1, 31'd0);
    send_req(8'd3, 31'd0);
    send_req(8'd255, 31'd256);
    send_req(8'd170, 31'd1);
    send_req(8'd255, 31'd0);
    send_req(8'd85, 31'd1 << 30);
    send_req(8'd85, 31'h7FFF_FFFF);
    send_req(8'd4, 31'd64);
    send_req(8'd5, 31'd64);
    send_req(8'd6, 31'd64);
    send_req(8'd7, 31'd64);
    send_req(8'd4, 31'd0);
    send_req(8'd6, 31'd0);
    send_req(8'd5, 31'd0);
    send_req(8'd7, 31'd0);
    drain();
  endtask

  task automatic test_bad_config();
    set_heap(8, 0);
    send_req(8'd1, 31'd8);
    set_heap(1, 29);
    send_req(8'd2, 31'd0);
    set_heap(20, 5);
    send_req(8'd3, 31'd1);
    set_heap(12, 12);
    send_req(8'd4, 31'd1);
    drain();
  endtask

  task automatic test_extreme_heaps();
    set_heap(30, 29);
    send_req(8'd1, 31'd1);
    send_req(8'd2, 31'd1 << 29);
    send_req(8'd3, 31'd1);
    send_req(8'd1, 31'd0);
    send_req(8'd3, 31'd1 << 30);
    set_heap(30, 20);
    send_req(8'd9, 31'd1);
    send_req(8'd10, 31'd1 << 30);
    send_req(8'd9, 31'd0);
    send_req(8'd10, 31'd1 << 30);
    send_req(8'd10, 31'd0);
    set_heap(2, 1);
    send_req(8'd1, 31'd2);
    send_req(8'd2, 31'd3);
    send_req(8'd3, 31'd1);
    send_req(8'd1, 31'd0);
    send_req(8'd2, 31'd0);
    drain();
  endtask

  task automatic random_traffic(int n_items, int snd, int stl);
    int          tot, lv, sh, roll;
    logic [7:0]  owner;
    logic [30:0] cnt;
    tot = $urandom_range(2, 30);
    lv  = $urandom_range(1, (tot - 1 < 5) ? tot - 1 : 5);
    set_heap(tot, tot - lv);
    send_pct  = snd;
    stall_pct = stl;
    for (int i = 0; i < n_items; i++) begin
      roll  = $urandom_range(0, 99);
      owner = 8'($urandom_range(0, 11));
      sh    = $urandom_range(0, tot);
      cnt   = 31'($urandom_range(1, 1 << sh));
      if (roll < 8) begin
        owner = 8'($urandom);
        cnt   = 31'($urandom_range(0, 1 << 30));
      end else if (roll < 12 && tot < 30) begin
        cnt = 31'((1 << tot) + $urandom_range(1, 1 << (30 - tot)));
      end else if (roll < 55) begin
        cnt = '0;
      end
      send_req(owner, cnt);
      // hold off until all responses are back
      if (i == n_items / 2) drain();
    end
    drain();
  endtask

  initial begin
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = '0;
    cfg_ch.data       = '0;
    req_ch.valid      = 1'b0;
    req_ch.owner      = '0;
    req_ch.byte_count = '0;
    heap_clear();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_bad_config();
    test_extreme_heaps();
    random_traffic(450, 0, 0);
    random_traffic(450, 56, 0);
    random_traffic(450, 0, 56);
    random_traffic(450, 19, 19);
    drain();
    repeat (50) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/bma_pkg.sv
rtl/bma_req_if.sv
rtl/bma_rsp_if.sv
rtl/bma_cfg_if.sv
rtl/bma_ctrl.sv
rtl/bma_dp.sv
rtl/buddy_memory_allocator.sv
dv/buddy_memory_allocator_tb.sv
